FILE: rtl/core/edm_pkg.sv
// Shared constants for the egg drop minimum trials block.
package edm_pkg;

    localparam int EDM_MAX_EGGS   = 128;
    localparam int EDM_MAX_FLOORS = 16384;
    localparam int EGGS_W         = 8;
    localparam int FLOORS_W       = 15;
    localparam int TRIALS_W       = 15;
    localparam int ENTRY_W        = 16;

    typedef logic [EGGS_W-1:0]   eggs_t;
    typedef logic [FLOORS_W-1:0] floors_t;
    typedef logic [TRIALS_W-1:0] trials_t;
    typedef logic [ENTRY_W-1:0]  entry_t;

endpackage

FILE: rtl/core/edm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module edm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/edm_core.sv
// Query sequencer and read-modify-write update of the coverage row.
module edm_core import edm_pkg::*; #(
    parameter int MAX_EGGS   = EDM_MAX_EGGS,
    parameter int MAX_FLOORS = EDM_MAX_FLOORS,
    localparam int IDX_W     = $clog2(MAX_EGGS),
    localparam int FL_W      = $clog2(MAX_FLOORS + 1),
    localparam int CMP_W     = (FL_W > ENTRY_W) ? FL_W : ENTRY_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  eggs_t            eggs,
    input  floors_t          floors,
    output logic             busy,
    output logic             done,
    output trials_t          trials,
    output logic             ram_we,
    output logic [IDX_W-1:0] ram_waddr,
    output entry_t           ram_wdata,
    output logic             ram_re,
    output logic [IDX_W-1:0] ram_raddr,
    input  entry_t           ram_rdata
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [FL_W-1:0]  floors_reg, floors_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic [IDX_W-1:0] iss_idx_reg, iss_idx_next;
    logic [FL_W-1:0]  iss_round_reg, iss_round_next;
    logic             iss_first_reg, iss_first_next;
    logic             s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0] s1_idx_reg, s1_idx_next;
    logic [FL_W-1:0]  s1_round_reg, s1_round_next;
    logic             s1_first_reg, s1_first_next;
    entry_t           carry_reg, carry_next;
    logic             done_reg, done_next;
    trials_t          trials_reg, trials_next;

    logic [FL_W-1:0]  floors_sat;
    eggs_t            eggs_m1;
    logic             one_egg;
    entry_t           old_val;
    entry_t           carry_use;
    entry_t           new_val;
    logic             hit;

    always_comb
    begin
        if (int'(floors) > MAX_FLOORS)
        begin
            floors_sat = FL_W'(MAX_FLOORS);
        end
        else
        begin
            floors_sat = FL_W'(floors);
        end
        one_egg = (eggs <= eggs_t'(1));
        eggs_m1 = eggs - eggs_t'(1);
    end

    always_comb
    begin
        old_val   = s1_first_reg ? '0 : ram_rdata;
        carry_use = (s1_idx_reg == '0) ? '0 : carry_reg;
        new_val   = old_val + carry_use + entry_t'(1);
        hit       = CMP_W'(new_val) >= CMP_W'(floors_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        floors_next    = floors_reg;
        last_idx_next  = last_idx_reg;
        iss_idx_next   = iss_idx_reg;
        iss_round_next = iss_round_reg;
        iss_first_next = iss_first_reg;
        s1_valid_next  = 1'b0;
        s1_idx_next    = iss_idx_reg;
        s1_round_next  = iss_round_reg;
        s1_first_next  = iss_first_reg;
        carry_next     = carry_reg;
        done_next      = 1'b0;
        trials_next    = trials_reg;
        ram_re         = 1'b0;
        ram_raddr      = iss_idx_reg;
        ram_we         = 1'b0;
        ram_waddr      = s1_idx_reg;
        ram_wdata      = new_val;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    floors_next = floors_sat;
                    if (int'(eggs) > MAX_EGGS)
                    begin
                        last_idx_next = IDX_W'(MAX_EGGS - 1);
                    end
                    else
                    begin
                        last_idx_next = IDX_W'(eggs_m1);
                    end
                    if (floors_sat == '0)
                    begin
                        done_next   = 1'b1;
                        trials_next = '0;
                    end
                    else if (one_egg)
                    begin
                        done_next   = 1'b1;
                        trials_next = TRIALS_W'(floors_sat);
                    end
                    else
                    begin
                        state_next     = S_RUN;
                        iss_idx_next   = '0;
                        iss_round_next = FL_W'(1);
                        iss_first_next = 1'b1;
                    end
                end
            end
            S_RUN:
            begin
                // issue the next read
                ram_re        = 1'b1;
                s1_valid_next = 1'b1;
                if (iss_idx_reg == last_idx_reg)
                begin
                    iss_idx_next   = '0;
                    iss_round_next = iss_round_reg + FL_W'(1);
                    iss_first_next = 1'b0;
                end
                else
                begin
                    iss_idx_next = iss_idx_reg + IDX_W'(1);
                end
                // update the entry whose data returned
                if (s1_valid_reg)
                begin
                    ram_we     = 1'b1;
                    carry_next = old_val;
                    if (hit)
                    begin
                        state_next    = S_IDLE;
                        s1_valid_next = 1'b0;
                        done_next     = 1'b1;
                        trials_next   = TRIALS_W'(s1_round_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= s1_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        floors_reg    <= floors_next;
        last_idx_reg  <= last_idx_next;
        iss_idx_reg   <= iss_idx_next;
        iss_round_reg <= iss_round_next;
        iss_first_reg <= iss_first_next;
        s1_idx_reg    <= s1_idx_next;
        s1_round_reg  <= s1_round_next;
        s1_first_reg  <= s1_first_next;
        carry_reg     <= carry_next;
        trials_reg    <= trials_next;
    end

    assign busy   = (state_reg == S_RUN);
    assign done   = done_reg;
    assign trials = trials_reg;

endmodule

FILE: rtl/core/egg_drop_min_trials.sv
// Top level of the egg drop minimum trials block.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------
//  query    | start, busy        | eggs, floors
//  result   | done (one cycle)   | trials
//
// A query with at most one egg or zero floors returns in the cycle after start.
// Otherwise the core walks the row entries in order through the coverage RAM read
// port, issuing the next read while the entry whose data returned is updated.
// The coverage row needs no clearing: the first round ignores the read data.
// busy is high while a query runs; done cannot be held off by the receiver.
module egg_drop_min_trials import edm_pkg::*; #(
    parameter int MAX_EGGS   = EDM_MAX_EGGS,
    parameter int MAX_FLOORS = EDM_MAX_FLOORS
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  eggs_t   eggs,
    input  floors_t floors,
    output logic    busy,
    output logic    done,
    output trials_t trials
);

    localparam int IDX_W = $clog2(MAX_EGGS);

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;

    edm_core #(
        .MAX_EGGS   (MAX_EGGS),
        .MAX_FLOORS (MAX_FLOORS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .eggs      (eggs),
        .floors    (floors),
        .busy      (busy),
        .done      (done),
        .trials    (trials),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    edm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_EGGS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: dv/egg_drop_min_trials_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the egg drop minimum trials block.
module egg_drop_min_trials_test;
    import edm_pkg::*;

    localparam int WATCHDOG_CYCLES = 10000;
    localparam int DRAIN_CYCLES    = 64;
    localparam int RANDOM_QUERIES  = 270;
    localparam int N_DIRECTED      = 22;

    typedef struct packed {
        eggs_t   e;
        floors_t f;
        logic    fixed_answer;
        trials_t answer;
    } query_row_t;

    // Rows with fixed_answer clear are checked against the trial predictor.
    localparam query_row_t DIRECTED [N_DIRECTED] = '{
        '{8'd1,   15'd1,     1'b1, 15'd1},
        '{8'd1,   15'd16384, 1'b1, 15'd16384},
        '{8'd1,   15'd32767, 1'b1, 15'd16384},
        '{8'd0,   15'd100,   1'b1, 15'd100},
        '{8'd0,   15'd32767, 1'b1, 15'd16384},
        '{8'd0,   15'd0,     1'b1, 15'd0},
        '{8'd5,   15'd0,     1'b1, 15'd0},
        '{8'd255, 15'd0,     1'b1, 15'd0},
        '{8'd2,   15'd1,     1'b1, 15'd1},
        '{8'd128, 15'd1,     1'b1, 15'd1},
        '{8'd255, 15'd1,     1'b1, 15'd1},
        '{8'd2,   15'd2,     1'b0, 15'd0},
        '{8'd2,   15'd100,   1'b0, 15'd0},
        '{8'd3,   15'd14,    1'b0, 15'd0},
        '{8'd2,   15'd16384, 1'b0, 15'd0},
        '{8'd2,   15'd32767, 1'b0, 15'd0},
        '{8'd128, 15'd16384, 1'b0, 15'd0},
        '{8'd255, 15'd16384, 1'b0, 15'd0},
        '{8'd128, 15'd32767, 1'b0, 15'd0},
        '{8'd200, 15'd1000,  1'b0, 15'd0},
        '{8'd127, 15'd5000,  1'b0, 15'd0},
        '{8'd4,   15'd16383, 1'b0, 15'd0}
    };

    logic    clk;
    logic    rst_n;
    logic    start;
    eggs_t   eggs;
    floors_t floors;
    logic    busy;
    logic    done;
    trials_t trials;

    trials_t     trials_due[$];
    trials_t     oldest_due;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    int unsigned sender_idle_pct;

    egg_drop_min_trials dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .eggs   (eggs),
        .floors (floors),
        .busy   (busy),
        .done   (done),
        .trials (trials)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic trials_t min_trials_for(input eggs_t e_in, input floors_t f_in);
        int unsigned e;
        int unsigned f;
        int unsigned rnd;
        int unsigned prev;
        int unsigned old;
        entry_t      row [EDM_MAX_EGGS];
        e = e_in;
        f = f_in;
        if (e == 0)
        begin
            e = 1;
        end
        if (e > EDM_MAX_EGGS)
        begin
            e = EDM_MAX_EGGS;
        end
        if (f > EDM_MAX_FLOORS)
        begin
            f = EDM_MAX_FLOORS;
        end
        if (f == 0)
        begin
            return '0;
        end
        if (e == 1)
        begin
            return trials_t'(f);
        end
        for (int i = 0; i < EDM_MAX_EGGS; i++)
        begin
            row[i] = '0;
        end
        rnd = 0;
        while (rnd < f)
        begin
            rnd++;
            prev = 0;
            for (int i = 0; i < e; i++)
            begin
                old    = row[i];
                row[i] = entry_t'(old + prev + 1);
                prev   = old;
                if (row[i] >= f)
                begin
                    return trials_t'(rnd);
                end
            end
        end
        return trials_t'(f);
    endfunction

    task automatic send_query(input eggs_t e, input floors_t f, input trials_t answer);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        eggs   <= e;
        floors <= f;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        trials_due.push_back(answer);
    endtask

    function automatic eggs_t pick_eggs();
        case ($urandom_range(9))
            0: return eggs_t'($urandom_range(0, 1));
            1: return eggs_t'($urandom_range(EDM_MAX_EGGS + 1, 255));
            2: return eggs_t'($urandom_range(0, 255));
            default: return eggs_t'($urandom_range(2, EDM_MAX_EGGS));
        endcase
    endfunction

    function automatic floors_t pick_floors();
        case ($urandom_range(9))
            0: return floors_t'($urandom_range(0, 32767));
            1: return floors_t'($urandom_range(EDM_MAX_FLOORS, 32767));
            2, 3: return floors_t'($urandom_range(1, 64));
            default: return floors_t'($urandom_range(1, EDM_MAX_FLOORS));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (trials_due.size() == 0)
            begin
                $error("trials: expected none, actual %0d", trials);
                mismatch_count <= mismatch_count + 1;
            end
            else
            begin
                oldest_due = trials_due.pop_front();
                if (trials !== oldest_due)
                begin
                    $error("trials: expected %0d, actual %0d", oldest_due, trials);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        eggs_t   e;
        floors_t f;
        rst_n           = 1'b0;
        start           = 1'b0;
        eggs            = '0;
        floors          = '0;
        sender_idle_pct = 18;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_query(DIRECTED[i].e, DIRECTED[i].f,
                       DIRECTED[i].fixed_answer ? DIRECTED[i].answer
                                                : min_trials_for(DIRECTED[i].e, DIRECTED[i].f));
        end

        for (int i = 0; i < RANDOM_QUERIES; i++)
        begin
            if (i == RANDOM_QUERIES / 3)
            begin
                sender_idle_pct = 51;
            end
            else if (i == 2 * RANDOM_QUERIES / 3)
            begin
                sender_idle_pct = 0;
            end
            e = pick_eggs();
            f = pick_floors();
            send_query(e, f, min_trials_for(e, f));
        end
        start <= 1'b0;

        while (trials_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
